>>> sv/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, codes and control types of the shelf rectangle allocator.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int SIDE_W    = 13;  // request sides, atlas sides, shelf height and used width
  localparam int TOP_W     = 13;  // stored shelf top row
  localparam int Y_W       = 15;  // next free row, may run past the atlas
  localparam int POS_W     = 12;
  localparam int OUT_IDX_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd1024;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_PLACE,
    S_OPEN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic do_clear;
    logic scan_start;
    logic scan_step;
    logic do_place;
    logic do_open;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic reject;
    logic no_shelves;
    logic hit;
    logic miss;
  } dp_status_t;

endpackage

>>> sv/sac_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_req_if
// Request channel: allocate or clear items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sac_req_if;
  import sac_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [SIDE_W-1:0] rect_width;
  logic [SIDE_W-1:0] rect_height;

  modport source (output valid, action, rect_width, rect_height, input ready);
  modport sink   (input valid, action, rect_width, rect_height, output ready);

endinterface

>>> sv/sac_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_rsp_if
// Result channel: placement of one item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sac_rsp_if;
  import sac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 placed;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [OUT_IDX_W-1:0] shelf_index;
  logic                 now_full;

  modport source (output valid, placed, pos_x, pos_y, shelf_index, now_full, input ready);
  modport sink   (input valid, placed, pos_x, pos_y, shelf_index, now_full, output ready);

endinterface

>>> sv/sac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: decides, scans shelves, places or opens a shelf, hands off item.
// ----------------------------------------------------------------------------
module sac_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sac_pkg::dp_status_t    status,
  output sac_pkg::ctrl_cmd_t     cmd
);
  import sac_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_space;

  assign out_space = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.is_clear || status.reject) state_next = S_RESULT;
        else if (status.no_shelves)           state_next = S_OPEN;
        else                                  state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.hit)       state_next = S_PLACE;
        else if (status.miss) state_next = S_OPEN;
      end
      S_PLACE:  state_next = S_RESULT;
      S_OPEN:   state_next = S_RESULT;
      S_RESULT: begin
        if (out_space) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.accept = in_valid;
      S_DECIDE: begin
        if (status.is_clear) begin
          cmd.do_clear = 1'b1;
        end else if (!status.reject && !status.no_shelves) begin
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN:   cmd.scan_step = 1'b1;
      S_PLACE:  cmd.do_place  = 1'b1;
      S_OPEN:   cmd.do_open   = 1'b1;
      S_RESULT: cmd.load_out  = out_space;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> sv/sac_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_dpath
// Shelf table, scan compare, shelf opening, atlas settings and result register.
// ----------------------------------------------------------------------------
module sac_dpath #(
  parameter int MAX_SHELVES = 64,
  parameter int MAX_SIDE    = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sac_pkg::SIDE_W-1:0]      cfg_data,
  input  logic                            action,
  input  logic [sac_pkg::SIDE_W-1:0]      rect_width,
  input  logic [sac_pkg::SIDE_W-1:0]      rect_height,
  input  sac_pkg::ctrl_cmd_t              cmd,
  output sac_pkg::dp_status_t             status,
  output logic                            placed,
  output logic [sac_pkg::POS_W-1:0]       pos_x,
  output logic [sac_pkg::POS_W-1:0]       pos_y,
  output logic [sac_pkg::OUT_IDX_W-1:0]   shelf_index,
  output logic                            now_full
);
  import sac_pkg::*;

  localparam int IDX_W  = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W  = $clog2(MAX_SHELVES + 1);
  localparam int WORD_W = TOP_W + 2 * SIDE_W;
  localparam int SIDE_TOP = (1 << SIDE_W) - 1;
  localparam logic [SIDE_W-1:0] SIDE_CAP =
    (MAX_SIDE > SIDE_TOP) ? {SIDE_W{1'b1}} : SIDE_W'(MAX_SIDE);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SHELVES);

  // settings
  logic [SIDE_W-1:0] atlas_width;
  logic [SIDE_W-1:0] atlas_height;
  logic [SIDE_W-1:0] aw;
  logic [SIDE_W-1:0] ah;

  // latched request
  logic              req_action;
  logic [SIDE_W-1:0] req_w;
  logic [SIDE_W-1:0] req_h;

  // allocator state
  logic [CNT_W-1:0]  shelf_count;
  logic              atlas_full;
  logic [Y_W-1:0]    open_y;

  // scan
  logic [CNT_W-1:0]  scan_addr;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [TOP_W-1:0]  hit_top;
  logic [SIDE_W-1:0] hit_tall;
  logic [SIDE_W-1:0] hit_used;

  // result
  logic              res_placed;
  logic [TOP_W-1:0]  res_x;
  logic [TOP_W-1:0]  res_y;
  logic [IDX_W-1:0]  res_idx;

  // shelf memory word: top, height, used width
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [TOP_W-1:0]  rd_top;
  logic [SIDE_W-1:0] rd_tall;
  logic [SIDE_W-1:0] rd_used;

  logic              fit;
  logic              hit;
  logic [Y_W:0]      open_bottom;
  logic              open_fits;
  logic              open_ok;

  assign aw = (atlas_width  > SIDE_CAP) ? SIDE_CAP : atlas_width;
  assign ah = (atlas_height > SIDE_CAP) ? SIDE_CAP : atlas_height;

  assign {rd_top, rd_tall, rd_used} = ram_rdata;

  assign fit = (rd_tall >= req_h) &&
               (({1'b0, rd_used} + {1'b0, req_w}) < {1'b0, aw});
  assign hit = pend && fit;

  assign open_bottom = {1'b0, open_y} + (Y_W + 1)'(req_h);
  assign open_fits   = open_bottom < (Y_W + 1)'(ah);
  assign open_ok     = open_fits && (shelf_count != CNT_MAX);

  assign status.is_clear   = (req_action == ACT_CLEAR);
  assign status.reject     = atlas_full || (req_w > aw) || (req_h > ah);
  assign status.no_shelves = (shelf_count == '0);
  assign status.hit        = hit;
  assign status.miss       = !hit && (scan_addr == shelf_count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = shelf_count[IDX_W-1:0];
    ram_wdata = {open_y[TOP_W-1:0], req_h, req_w + SIDE_W'(1)};
    if (cmd.do_place) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx;
      ram_wdata = {hit_top, hit_tall, hit_used + req_w + SIDE_W'(1)};
    end else if (cmd.do_open && open_ok) begin
      ram_we = 1'b1;
    end
  end

  sac_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SHELVES)
  ) u_shelf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= SIDE_RESET;
      atlas_height <= SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        CFG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shelf_count <= '0;
      atlas_full  <= 1'b0;
      open_y      <= '0;
      pend        <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        shelf_count <= '0;
        atlas_full  <= 1'b0;
        open_y      <= '0;
      end
      if (cmd.do_open) begin
        if (!open_fits) begin
          atlas_full <= 1'b1;
        end else if (open_ok) begin
          shelf_count <= shelf_count + CNT_W'(1);
          open_y      <= open_bottom[Y_W-1:0] + Y_W'(1);
        end
      end
      if (cmd.scan_start) begin
        pend <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= (scan_addr != shelf_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_action <= action;
      req_w      <= rect_width;
      req_h      <= rect_height;
      res_placed <= 1'b0;
      res_x      <= '0;
      res_y      <= '0;
      res_idx    <= '0;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      // one read issued per cycle, its data compared in the next
      if (scan_addr != shelf_count) begin
        scan_addr <= scan_addr + CNT_W'(1);
        pend_idx  <= scan_addr[IDX_W-1:0];
      end
      if (hit) begin
        hit_idx  <= pend_idx;
        hit_top  <= rd_top;
        hit_tall <= rd_tall;
        hit_used <= rd_used;
      end
    end
    if (cmd.do_place) begin
      res_placed <= 1'b1;
      res_x      <= hit_used;
      res_y      <= hit_top;
      res_idx    <= hit_idx;
    end
    if (cmd.do_open && open_ok) begin
      res_placed <= 1'b1;
      res_x      <= '0;
      res_y      <= open_y[TOP_W-1:0];
      res_idx    <= shelf_count[IDX_W-1:0];
    end
    if (cmd.load_out) begin
      placed      <= res_placed;
      pos_x       <= res_x[POS_W-1:0];
      pos_y       <= res_y[POS_W-1:0];
      shelf_index <= OUT_IDX_W'(res_idx);
      now_full    <= atlas_full;
    end
  end

endmodule

>>> sv/shelf_rect_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shelf_rect_allocator
// First-fit shelf allocator for a 2D texture atlas.
// ----------------------------------------------------------------------------
// One item at a time. A clear, or an allocate that is rejected at once (atlas
// full or rectangle larger than the atlas), goes from the decide state straight
// to the result state. An allocate scans the open shelves up to the first one
// that fits and places the item there, or tries to open a new shelf when none
// fits or no shelf is open yet; the shelf table sits in one memory read one
// entry per cycle, up to MAX_SHELVES entries. A clear takes effect at once
// through the shelf count, with no sweep of the memory. The result sits in an
// output register, so the next item is taken while it waits. Atlas width and
// height are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module shelf_rect_allocator #(
  parameter int MAX_SHELVES = 64,
  parameter int MAX_SIDE    = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sac_pkg::SIDE_W-1:0]    cfg_data,
  sac_req_if.sink                       req,
  sac_rsp_if.source                     rsp
);
  import sac_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sac_dpath #(
    .MAX_SHELVES (MAX_SHELVES),
    .MAX_SIDE    (MAX_SIDE)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (req.action),
    .rect_width  (req.rect_width),
    .rect_height (req.rect_height),
    .cmd         (cmd),
    .status      (status),
    .placed      (rsp.placed),
    .pos_x       (rsp.pos_x),
    .pos_y       (rsp.pos_y),
    .shelf_index (rsp.shelf_index),
    .now_full    (rsp.now_full)
  );

endmodule

>>> tb/tb_shelf_rect_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shelf_rect_allocator
// Self-checking bench for the first-fit shelf allocator. A shelf model in the
// bench places every accepted request; each result is compared field by field
// against the oldest placement still owed. Directed cases cover the atlas
// edges, oversize and full handling and clear, then random phases run over
// several atlas sizes with bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_shelf_rect_allocator;
  import sac_pkg::*;

  localparam int SHELVES     = 64;
  localparam int SIDE_MAX    = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = SHELVES + 20;
  localparam int HOLD_CYCLES = 400;

  localparam logic ACT_ALLOC = ~ACT_CLEAR;

  typedef struct packed {
    logic                 placed;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [OUT_IDX_W-1:0] shelf_index;
    logic                 now_full;
  } placement_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIDE_W-1:0]    cfg_data;

  sac_req_if req_ch ();
  sac_rsp_if rsp_ch ();

  shelf_rect_allocator #(
    .MAX_SHELVES(SHELVES),
    .MAX_SIDE   (SIDE_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // shelf model state
  int                row_top [SHELVES];
  int                row_tall[SHELVES];
  int                row_used[SHELVES];
  int                rows_open;
  bit                atlas_is_full;
  logic [SIDE_W-1:0] cfg_width;
  logic [SIDE_W-1:0] cfg_height;

  placement_t pending_placements[$];
  int         errors;

  int       burst_left;
  int       sender_gap_max;
  int       rx_hold_left;
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_beat;
  int       idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic placement_t place_rect(logic act, logic [SIDE_W-1:0] w,
                                            logic [SIDE_W-1:0] h);
    placement_t r;
    int         aw;
    int         ah;
    int         y;
    int         slot;
    int         i;
    bit         hit;
    r    = '0;
    aw   = (cfg_width > SIDE_MAX) ? SIDE_MAX : cfg_width;
    ah   = (cfg_height > SIDE_MAX) ? SIDE_MAX : cfg_height;
    hit  = 1'b0;
    slot = 0;
    if (act == ACT_CLEAR) begin
      rows_open     = 0;
      atlas_is_full = 1'b0;
    end else if (!atlas_is_full && w <= aw && h <= ah) begin
      for (i = 0; i < rows_open; i++) begin
        if (!hit && row_tall[i] >= h && row_used[i] + w < aw) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        y = 0;
        if (rows_open > 0) y = row_top[rows_open-1] + row_tall[rows_open-1] + 1;
        if (y + h < ah) begin
          // table exhausted fails without latching full
          if (rows_open < SHELVES) begin
            slot           = rows_open;
            row_top[slot]  = y;
            row_tall[slot] = h;
            row_used[slot] = 0;
            rows_open++;
            hit = 1'b1;
          end
        end else begin
          atlas_is_full = 1'b1;
        end
      end
      if (hit) begin
        r.placed       = 1'b1;
        r.pos_x        = POS_W'(row_used[slot]);
        r.pos_y        = POS_W'(row_top[slot]);
        r.shelf_index  = OUT_IDX_W'(slot);
        row_used[slot] = (row_used[slot] + w + 1) & 'h1FFF;
      end
    end
    r.now_full = atlas_is_full;
    return r;
  endfunction

  // bursts of items with random gaps; returns at the accepting edge
  task automatic send_item(input logic act, input logic [SIDE_W-1:0] w,
                           input logic [SIDE_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, sender_gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.rect_width  <= w;
    req_ch.rect_height <= h;
    do @(posedge clk); while (!req_ch.ready);
    pending_placements.insert(pending_placements.size(), place_rect(act, w, h));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  task automatic set_atlas(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_width  = w;
    cfg_height = h;
  endtask

  // reset geometry: zero sized items, width fit, new shelves
  task automatic test_basic_placement();
    sender_gap_max = 3;
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 1023, 0);
    send_item(ACT_ALLOC, 1024, 5);
    send_item(ACT_ALLOC, 10, 3);
    wait_drained();
  endtask

  task automatic test_oversize();
    send_item(ACT_ALLOC, 1025, 1);
    send_item(ACT_ALLOC, 1, 1025);
    send_item(ACT_ALLOC, 8191, 8191);
    send_item(ACT_ALLOC, 4096, 0);
    wait_drained();
  endtask

  task automatic test_full_and_clear();
    send_item(ACT_ALLOC, 5, 1016);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 7, 1023);
    send_item(ACT_ALLOC, 7, 1024);
    send_item(ACT_CLEAR, 8191, 8191);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    set_atlas(1, 1);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_CLEAR, 0, 0);
    wait_drained();
    set_atlas(0, 0);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_CLEAR, 0, 0);
    wait_drained();
    // both sides clamp to the largest atlas
    set_atlas(8191, 8191);
    send_item(ACT_ALLOC, 4094, 10);
    send_item(ACT_ALLOC, 0, 5);
    send_item(ACT_ALLOC, 4096, 4085);
    send_item(ACT_CLEAR, 0, 0);
    send_item(ACT_ALLOC, 4095, 4094);
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 1, 0);
    send_item(ACT_ALLOC, 1, 1);
    wait_drained();
  endtask

  // sink holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    set_atlas(1024, 1024);
    send_item(ACT_CLEAR, 0, 0);
    sender_gap_max = 0;
    rx_hold_left   = HOLD_CYCLES;
    repeat (25) send_item(ACT_ALLOC, SIDE_W'($urandom_range(0, 200)),
                          SIDE_W'($urandom_range(0, 40)));
    wait_drained();
  endtask

  task automatic test_random_phase(input logic [SIDE_W-1:0] aw, input logic [SIDE_W-1:0] ah,
                                   input int w_max, input int h_max, input int count,
                                   input int clear_pct, input int gap);
    int pick;
    set_atlas(aw, ah);
    sender_gap_max = gap;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < clear_pct || (atlas_is_full && pick < 40)) begin
        send_item(ACT_CLEAR, SIDE_W'($urandom_range(0, 8191)),
                  SIDE_W'($urandom_range(0, 8191)));
      end else if (pick >= 95) begin
        send_item(ACT_ALLOC, SIDE_W'($urandom_range(0, 8191)),
                  SIDE_W'($urandom_range(0, 8191)));
      end else begin
        send_item(ACT_ALLOC, SIDE_W'($urandom_range(0, w_max)),
                  SIDE_W'($urandom_range(0, h_max)));
      end
    end
    wait_drained();
  endtask

  task automatic test_random();
    int k;
    int aw;
    int ah;
    test_random_phase(1024, 1024, 300, 60, 150, 2, 4);
    test_random_phase(4096, 4096, 1500, 200, 150, 2, 0);
    test_random_phase(64, 4096, 64, 30, 150, 1, 3);
    test_random_phase(4096, 80, 2000, 20, 150, 3, 8);
    test_random_phase(8191, 5000, 4096, 600, 150, 2, 2);
    test_random_phase(1, 4096, 1, 100, 150, 2, 5);
    test_random_phase(4096, 1, 4096, 1, 150, 5, 1);
    test_random_phase(100, 100, 100, 20, 150, 3, 6);
    for (k = 0; k < 4; k++) begin
      aw = $urandom_range(1, 4096);
      ah = $urandom_range(1, 4096);
      test_random_phase(SIDE_W'(aw), SIDE_W'(ah), $urandom_range(0, aw),
                        $urandom_range(0, ah / 4), 150,
                        $urandom_range(1, 4), $urandom_range(0, 10));
    end
  endtask

  // result sink: stall pattern plus field checks
  always @(posedge clk) begin
    placement_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_placements.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = pending_placements.pop_front();
        if (rsp_ch.placed !== want.placed) begin
          $error("placed: expected %0d, actual %0d", want.placed, rsp_ch.placed);
          errors++;
        end
        if (rsp_ch.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, actual %0d", want.pos_x, rsp_ch.pos_x);
          errors++;
        end
        if (rsp_ch.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, actual %0d", want.pos_y, rsp_ch.pos_y);
          errors++;
        end
        if (rsp_ch.shelf_index !== want.shelf_index) begin
          $error("shelf_index: expected %0d, actual %0d", want.shelf_index,
                 rsp_ch.shelf_index);
          errors++;
        end
        if (rsp_ch.now_full !== want.now_full) begin
          $error("now_full: expected %0d, actual %0d", want.now_full, rsp_ch.now_full);
          errors++;
        end
      end
    end
    if (rx_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(50, 300);
        rx_beat      = 0;
      end
      rx_mode_left--;
      rx_beat++;
      case (rx_mode)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_ch.ready <= (rx_beat % 7) >= 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("shelf_rect_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_ATLAS_WIDTH;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_ALLOC;
    req_ch.rect_width  = '0;
    req_ch.rect_height = '0;
    rsp_ch.ready       = 1'b0;
    cfg_width          = SIDE_RESET;
    cfg_height         = SIDE_RESET;
    rows_open          = 0;
    atlas_is_full      = 1'b0;
    errors             = 0;
    burst_left         = 0;
    sender_gap_max     = 0;
    rx_hold_left       = 0;
    rx_mode            = RX_OPEN;
    rx_mode_left       = 0;
    rx_beat            = 0;
    idle_cycles        = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_basic_placement();
    test_oversize();
    test_full_and_clear();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("shelf_rect_allocator verification clean");
    end else begin
      $display("shelf_rect_allocator verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sac_pkg.sv
sv/sac_req_if.sv
sv/sac_rsp_if.sv
sv/sac_ram.sv
sv/sac_ctrl.sv
sv/sac_dpath.sv
sv/shelf_rect_allocator.sv
tb/tb_shelf_rect_allocator.sv
